FILE: hdl/glsr_pkg.sv
// Shared types and constants of the grid line smoothness ratio block.
`timescale 1ns / 1ps

package glsr_pkg;

  // Result format: unsigned Q16.16.
  localparam int RESULT_W = 32;
  localparam logic [RESULT_W-1:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [RESULT_W-1:0] SAT_Q16 = 32'hFFFF_FFFF;
  localparam logic [RESULT_W-1:0] ZERO_Q16 = 32'h0000_0000;

  // The quotient big * 2^32 / small is formed to 64 bits, its root to 32 bits.
  localparam int FRAC_W = 32;
  localparam int QUO_W = 64;
  localparam int DIV_STEPS = 64;
  localparam int ROOT_STEPS = 32;
  localparam int STEP_CNT_W = 6;
  // Partial remainder of the root needs two bits more than the root.
  localparam int ROOT_REM_W = RESULT_W + 2;

  // How many nodes of the current line are held in the window.
  typedef enum logic [1:0] {
    FILL_EMPTY = 2'd0,
    FILL_ONE   = 2'd1,
    FILL_TWO   = 2'd2
  } fill_t;

  // Top-level request sequencer.
  typedef enum logic [1:0] {
    T_IDLE = 2'd0,
    T_PLAN = 2'd1,
    T_CALC = 2'd2,
    T_EMIT = 2'd3
  } top_state_t;

  // Ratio unit sequencer.
  typedef enum logic [2:0] {
    E_IDLE  = 3'd0,
    E_MUL   = 3'd1,
    E_ADD   = 3'd2,
    E_ORDER = 3'd3,
    E_SAT   = 3'd4,
    E_DIV   = 3'd5,
    E_ROOT  = 3'd6,
    E_DONE  = 3'd7
  } eng_state_t;

endpackage

FILE: hdl/glsr_ratio_unit.sv
// Iterative ratio unit: squared edge lengths, long division and square root.
`timescale 1ns / 1ps

module glsr_ratio_unit #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start_i,
  input  logic signed [COORD_WIDTH-1:0]    older_x_i,
  input  logic signed [COORD_WIDTH-1:0]    older_y_i,
  input  logic signed [COORD_WIDTH-1:0]    newer_x_i,
  input  logic signed [COORD_WIDTH-1:0]    newer_y_i,
  input  logic signed [COORD_WIDTH-1:0]    item_x_i,
  input  logic signed [COORD_WIDTH-1:0]    item_y_i,
  output logic                             done_o,
  output logic [glsr_pkg::RESULT_W-1:0]    result_o
);

  localparam int PROD_W = 2 * COORD_WIDTH;
  localparam int SQ_W = 2 * COORD_WIDTH + 1;
  localparam int SU_W = (SQ_W + 1 > glsr_pkg::ROOT_REM_W) ? SQ_W + 1 : glsr_pkg::ROOT_REM_W;
  localparam int REM_W = SU_W - 1;
  localparam int QW = glsr_pkg::QUO_W;
  localparam int CW = glsr_pkg::STEP_CNT_W;
  localparam int RW = glsr_pkg::RESULT_W;

  glsr_pkg::eng_state_t state_r, state_nxt;

  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [SQ_W-1:0]  a_len_r, a_len_nxt;
  logic [SQ_W-1:0]  b_len_r, b_len_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [QW-1:0]    dq_r, dq_nxt;
  logic [RW-1:0]    root_r, root_nxt;

  // Coordinate difference and its magnitude for the current square.
  logic [COORD_WIDTH-1:0] diff_hi, diff_lo;
  logic [COORD_WIDTH:0]   diff, diff_mag;
  logic [COORD_WIDTH-1:0] diff_abs;

  // Shared adder / subtractor.
  logic [SU_W-1:0] su_a, su_b;
  logic            su_sub;
  logic [SU_W:0]   su_res;
  logic            su_borrow;

  logic [QW-1:0]   big_ext;
  logic [SQ_W-1:0] big_hi;
  logic            len_zero;
  logic            step_last_div, step_last_root;

  always_comb begin
    case (cnt_r[1:0])
      2'd0: begin
        diff_hi = newer_x_i;
        diff_lo = older_x_i;
      end
      2'd1: begin
        diff_hi = newer_y_i;
        diff_lo = older_y_i;
      end
      2'd2: begin
        diff_hi = item_x_i;
        diff_lo = newer_x_i;
      end
      default: begin
        diff_hi = item_y_i;
        diff_lo = newer_y_i;
      end
    endcase
  end

  assign diff     = {diff_hi[COORD_WIDTH-1], diff_hi} - {diff_lo[COORD_WIDTH-1], diff_lo};
  assign diff_mag = diff[COORD_WIDTH] ? (~diff + {{COORD_WIDTH{1'b0}}, 1'b1}) : diff;
  assign diff_abs = diff_mag[COORD_WIDTH-1:0];

  assign big_ext = QW'(a_len_r);
  assign big_hi  = SQ_W'(big_ext >> glsr_pkg::FRAC_W);
  assign len_zero = (a_len_r == '0) || (b_len_r == '0);
  assign step_last_div  = (cnt_r == CW'(glsr_pkg::DIV_STEPS - 1));
  assign step_last_root = (cnt_r == CW'(glsr_pkg::ROOT_STEPS - 1));

  // Operand selection for the shared unit.
  always_comb begin
    su_a   = '0;
    su_b   = '0;
    su_sub = 1'b0;
    unique case (state_r)
      glsr_pkg::E_ADD: begin
        su_a = cnt_r[0] ? (cnt_r[1] ? SU_W'(b_len_r) : SU_W'(a_len_r)) : '0;
        su_b = SU_W'(prod_r);
      end
      glsr_pkg::E_ORDER: begin
        su_a   = SU_W'(a_len_r);
        su_b   = SU_W'(b_len_r);
        su_sub = 1'b1;
      end
      glsr_pkg::E_SAT: begin
        su_a   = SU_W'(big_hi);
        su_b   = SU_W'(b_len_r);
        su_sub = 1'b1;
      end
      glsr_pkg::E_DIV: begin
        su_a   = SU_W'({rem_r[SQ_W-1:0], dq_r[QW-1]});
        su_b   = SU_W'(b_len_r);
        su_sub = 1'b1;
      end
      glsr_pkg::E_ROOT: begin
        su_a   = SU_W'({rem_r[RW-1:0], dq_r[QW-1:QW-2]});
        su_b   = SU_W'({root_r, 2'b01});
        su_sub = 1'b1;
      end
      default: begin
        su_a = '0;
      end
    endcase
  end

  assign su_res = {1'b0, su_a} + ({1'b0, su_b} ^ {(SU_W + 1){su_sub}})
                  + (SU_W + 1)'(su_sub);
  assign su_borrow = su_res[SU_W];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      glsr_pkg::E_IDLE:  if (start_i) state_nxt = glsr_pkg::E_MUL;
      glsr_pkg::E_MUL:   state_nxt = glsr_pkg::E_ADD;
      glsr_pkg::E_ADD:   state_nxt = (cnt_r[1:0] == 2'd3) ? glsr_pkg::E_ORDER
                                                          : glsr_pkg::E_MUL;
      glsr_pkg::E_ORDER: state_nxt = len_zero ? glsr_pkg::E_DONE : glsr_pkg::E_SAT;
      glsr_pkg::E_SAT:   state_nxt = su_borrow ? glsr_pkg::E_DIV : glsr_pkg::E_DONE;
      glsr_pkg::E_DIV:   if (step_last_div) state_nxt = glsr_pkg::E_ROOT;
      glsr_pkg::E_ROOT:  if (step_last_root) state_nxt = glsr_pkg::E_DONE;
      glsr_pkg::E_DONE:  state_nxt = glsr_pkg::E_IDLE;
      default:           state_nxt = glsr_pkg::E_IDLE;
    endcase
  end

  // Datapath updates.
  always_comb begin
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    a_len_nxt = a_len_r;
    b_len_nxt = b_len_r;
    rem_nxt   = rem_r;
    dq_nxt    = dq_r;
    root_nxt  = root_r;
    unique case (state_r)
      glsr_pkg::E_IDLE: begin
        if (start_i) cnt_nxt = '0;
      end
      glsr_pkg::E_MUL: begin
        prod_nxt = diff_abs * diff_abs;
      end
      glsr_pkg::E_ADD: begin
        if (cnt_r[1]) b_len_nxt = su_res[SQ_W-1:0];
        else a_len_nxt = su_res[SQ_W-1:0];
        cnt_nxt = cnt_r + CW'(1);
      end
      glsr_pkg::E_ORDER: begin
        if (len_zero) begin
          root_nxt = glsr_pkg::ONE_Q16;
        end else if (su_borrow) begin
          // Keep the longer edge in a_len and the shorter in b_len.
          a_len_nxt = b_len_r;
          b_len_nxt = a_len_r;
        end
      end
      glsr_pkg::E_SAT: begin
        if (!su_borrow) begin
          root_nxt = glsr_pkg::SAT_Q16;
        end else begin
          rem_nxt = REM_W'(big_hi);
          dq_nxt  = {big_ext[glsr_pkg::FRAC_W-1:0], {glsr_pkg::FRAC_W{1'b0}}};
          cnt_nxt = '0;
        end
      end
      glsr_pkg::E_DIV: begin
        dq_nxt = {dq_r[QW-2:0], ~su_borrow};
        if (step_last_div) begin
          rem_nxt  = '0;
          root_nxt = '0;
          cnt_nxt  = '0;
        end else begin
          rem_nxt = su_borrow ? REM_W'(su_a) : REM_W'(su_res);
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      glsr_pkg::E_ROOT: begin
        rem_nxt  = su_borrow ? REM_W'(su_a) : REM_W'(su_res);
        root_nxt = {root_r[RW-2:0], ~su_borrow};
        dq_nxt   = {dq_r[QW-3:0], 2'b00};
        cnt_nxt  = cnt_r + CW'(1);
      end
      glsr_pkg::E_DONE: begin
        cnt_nxt = '0;
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_comb begin
    done_o   = (state_r == glsr_pkg::E_DONE);
    result_o = root_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= glsr_pkg::E_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    a_len_r <= a_len_nxt;
    b_len_r <= b_len_nxt;
    rem_r   <= rem_nxt;
    dq_r    <= dq_nxt;
    root_r  <= root_nxt;
  end

endmodule

FILE: hdl/grid_line_smoothness_ratio_core.sv
// Top level of the grid line smoothness ratio block.
`timescale 1ns / 1ps

// Grid nodes arrive one request at a time along a grid line; every node gives
// exactly one result, in node order. For an inner node the result is
// sqrt(longer squared edge / shorter squared edge) in unsigned Q16.16,
// truncated and saturated at 0xFFFFFFFF, and 1.0 when either edge has zero
// length. Line ends and nodes with an invalid neighbor come out with
// value_missing set and a value of zero. A node's result leaves when the next
// node arrives, and a line end's result leaves on its own arrival, so one
// input request gives zero, one or two results; last_in_run marks the final
// one. The block handles one input request at a time: in_stall is high from
// acceptance until every result of that request has been taken. A request
// that needs a ratio runs through the ratio unit: the two squared lengths
// through one multiplier, ordering and the saturation check, the bit-serial
// division and the bit-serial root, all on one shared subtractor, and the
// hand-over of the result. A zero-length edge ends the computation after
// the ordering step, saturation after the saturation check.

module grid_line_smoothness_ratio_core #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_node_x,
  input  logic signed [COORD_WIDTH-1:0] in_node_y,
  input  logic                          in_node_valid,
  input  logic                          in_first_in_line,
  input  logic                          in_last_in_line,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [glsr_pkg::RESULT_W-1:0] out_smoothness_value,
  output logic                          out_value_missing,
  output logic                          out_last_in_run
);

  glsr_pkg::top_state_t state_r, state_nxt;
  glsr_pkg::fill_t      fill_r, fill_nxt;

  // The accepted request, held until all its results are planned.
  logic signed [COORD_WIDTH-1:0] item_x_r, item_y_r;
  logic item_valid_r, item_first_r, item_last_r;

  // Window of the two previous nodes on the line.
  logic signed [COORD_WIDTH-1:0] older_x_r, older_y_r, newer_x_r, newer_y_r;
  logic signed [COORD_WIDTH-1:0] older_x_nxt, older_y_nxt, newer_x_nxt, newer_y_nxt;
  logic older_valid_r, newer_valid_r, older_valid_nxt, newer_valid_nxt;

  // Output register and the flag for a second, missing result.
  logic [glsr_pkg::RESULT_W-1:0] value_r, value_nxt;
  logic missing_r, missing_nxt, last_r, last_nxt, pend_r, pend_nxt;

  logic in_take;
  logic is_one, is_two, eff_empty, restart2, mid, all_ok;
  logic need_calc, plan_emit, plan_pend, plan_last1, commit;
  logic eng_start, eng_done;
  logic [glsr_pkg::RESULT_W-1:0] eng_result;

  assign in_take = in_valid && (state_r == glsr_pkg::T_IDLE);

  // Plan of the results for the held request. A line start while a node
  // waits flushes that node as missing before the new line begins; a node
  // that arrives with no line open starts one.
  assign is_one    = (fill_r == glsr_pkg::FILL_ONE);
  assign is_two    = (fill_r == glsr_pkg::FILL_TWO);
  assign restart2  = item_first_r && is_two;
  assign eff_empty = item_first_r || !(is_one || is_two);
  assign mid       = !eff_empty && is_two;
  assign all_ok    = older_valid_r && newer_valid_r && item_valid_r;
  assign need_calc = mid && all_ok;
  assign plan_emit = restart2 || eff_empty || mid || (is_one && item_last_r);
  assign plan_pend = restart2 || (mid && item_last_r);
  assign plan_last1 = restart2 ? 1'b0 : (mid ? !item_last_r : 1'b1);

  // The window moves once the ratio unit no longer needs the old nodes.
  assign commit = ((state_r == glsr_pkg::T_PLAN) && !need_calc)
                || ((state_r == glsr_pkg::T_CALC) && eng_done);

  glsr_ratio_unit #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_ratio (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (eng_start),
    .older_x_i(older_x_r),
    .older_y_i(older_y_r),
    .newer_x_i(newer_x_r),
    .newer_y_i(newer_y_r),
    .item_x_i (item_x_r),
    .item_y_i (item_y_r),
    .done_o   (eng_done),
    .result_o (eng_result)
  );

  // Next state of the request sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      glsr_pkg::T_IDLE: begin
        if (in_valid) state_nxt = glsr_pkg::T_PLAN;
      end
      glsr_pkg::T_PLAN: begin
        if (need_calc) state_nxt = glsr_pkg::T_CALC;
        else if (plan_emit) state_nxt = glsr_pkg::T_EMIT;
        else state_nxt = glsr_pkg::T_IDLE;
      end
      glsr_pkg::T_CALC: begin
        if (eng_done) state_nxt = glsr_pkg::T_EMIT;
      end
      glsr_pkg::T_EMIT: begin
        if (!out_stall && !pend_r) state_nxt = glsr_pkg::T_IDLE;
      end
      default: state_nxt = glsr_pkg::T_IDLE;
    endcase
  end

  // Sequencer outputs and the result register.
  always_comb begin
    in_stall    = (state_r != glsr_pkg::T_IDLE);
    out_valid   = (state_r == glsr_pkg::T_EMIT);
    eng_start   = 1'b0;
    value_nxt   = value_r;
    missing_nxt = missing_r;
    last_nxt    = last_r;
    pend_nxt    = pend_r;
    unique case (state_r)
      glsr_pkg::T_IDLE: begin
        pend_nxt = 1'b0;
      end
      glsr_pkg::T_PLAN: begin
        if (need_calc) begin
          eng_start = 1'b1;
          pend_nxt  = item_last_r;
        end else if (plan_emit) begin
          value_nxt   = glsr_pkg::ZERO_Q16;
          missing_nxt = 1'b1;
          last_nxt    = plan_last1;
          pend_nxt    = plan_pend;
        end
      end
      glsr_pkg::T_CALC: begin
        if (eng_done) begin
          value_nxt   = eng_result;
          missing_nxt = 1'b0;
          last_nxt    = !item_last_r;
        end
      end
      glsr_pkg::T_EMIT: begin
        // The second result of a request is always missing: a line end, or the node that opens a new line.
        if (!out_stall && pend_r) begin
          value_nxt   = glsr_pkg::ZERO_Q16;
          missing_nxt = 1'b1;
          last_nxt    = 1'b1;
          pend_nxt    = 1'b0;
        end
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  // Window update for the held request.
  always_comb begin
    fill_nxt        = fill_r;
    older_x_nxt     = older_x_r;
    older_y_nxt     = older_y_r;
    older_valid_nxt = older_valid_r;
    newer_x_nxt     = newer_x_r;
    newer_y_nxt     = newer_y_r;
    newer_valid_nxt = newer_valid_r;
    if (commit) begin
      if (item_last_r) begin
        fill_nxt = glsr_pkg::FILL_EMPTY;
      end else begin
        if (eff_empty) begin
          fill_nxt = glsr_pkg::FILL_ONE;
        end else begin
          older_x_nxt     = newer_x_r;
          older_y_nxt     = newer_y_r;
          older_valid_nxt = newer_valid_r;
          fill_nxt        = glsr_pkg::FILL_TWO;
        end
        newer_x_nxt     = item_x_r;
        newer_y_nxt     = item_y_r;
        newer_valid_nxt = item_valid_r;
      end
    end
  end

  assign out_smoothness_value = value_r;
  assign out_value_missing    = missing_r;
  assign out_last_in_run      = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= glsr_pkg::T_IDLE;
      fill_r        <= glsr_pkg::FILL_EMPTY;
      pend_r        <= 1'b0;
      older_valid_r <= 1'b0;
      newer_valid_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      fill_r        <= fill_nxt;
      pend_r        <= pend_nxt;
      older_valid_r <= older_valid_nxt;
      newer_valid_r <= newer_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_x_r     <= in_node_x;
      item_y_r     <= in_node_y;
      item_valid_r <= in_node_valid;
      item_first_r <= in_first_in_line;
      item_last_r  <= in_last_in_line;
    end
    older_x_r <= older_x_nxt;
    older_y_r <= older_y_nxt;
    newer_x_r <= newer_x_nxt;
    newer_y_r <= newer_y_nxt;
    value_r   <= value_nxt;
    missing_r <= missing_nxt;
    last_r    <= last_nxt;
  end

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the grid line smoothness ratio core.
`timescale 1ns / 1ps

// The testbench feeds grid nodes into grid_line_smoothness_ratio_core and
// checks every result against its own model of the block.
//
// The model keeps the same two-node window as the block: the older and the
// newer node of the current line and how many of them are held. When a node
// is accepted, the model works out the results that the node releases:
//   - zero, one or two results per request;
//   - the last one always carries last_in_run.
// These expected results go onto a queue. Each result that the block hands
// over is compared field by field with the oldest entry. A result that
// arrives with nothing expected is an error. A wrong field is an error.
// Entries still queued at the timeout also end the run as a failure.
//
// The stimulus has two parts.
//   - A short directed table covers the cases that decide the block's
//     behavior: line starts and ends, single-node lines, restarts inside a
//     line, nodes that arrive with no line open, and invalid nodes in every
//     window position. It also covers zero-length edges, equal edges and a
//     saturating ratio at the coordinate extremes. Rows whose answer is
//     plain from the rules carry it typed in. The other rows are checked
//     against the model.
//   - The random part is built mostly from well-formed lines of random
//     length. Along a line the coordinates wander with steps of random
//     scale, and zero steps, extremes and full-range jumps are mixed in.
//     About one draw in ten is a single item of pure noise with random marks.
// Both sides idle in random bursts, in phases that come and go, so that
// gaps land on every stage of the block's long ratio computation. The last
// stretch of the run has no idling at all.

module testbench;

  localparam int COORD_W      = 24;
  localparam int NUM_ROWS     = 23;
  localparam int RANDOM_ITEMS = 830;
  // Idling stops for the last CALM_ITEMS random requests.
  localparam int CALM_ITEMS   = 80;
  localparam int DRAIN_CYCLES = 200;
  // Leave ample margin over the length of a slow correct run.
  localparam int CYCLE_LIMIT  = 1_000_000;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = coord_t'((1 << (COORD_W - 1)) - 1);
  localparam coord_t COORD_MIN = coord_t'(1 << (COORD_W - 1));

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   node_valid;
    logic   first;
    logic   last;
  } node_t;

  typedef struct packed {
    logic [glsr_pkg::RESULT_W-1:0] value;
    logic                          missing;
    logic                          last_in_run;
  } result_t;

  // One row of the directed table. A typed count of -1 means that the
  // expected results come from the model.
  typedef struct packed {
    node_t   nd;
    int      typed_count;
    result_t typed_a;
    result_t typed_b;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_stall;
  coord_t                        in_node_x = '0;
  coord_t                        in_node_y = '0;
  logic                          in_node_valid = 1'b0;
  logic                          in_first_in_line = 1'b0;
  logic                          in_last_in_line = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [glsr_pkg::RESULT_W-1:0] out_smoothness_value;
  logic                          out_value_missing;
  logic                          out_last_in_run;

  // The model's window state.
  glsr_pkg::fill_t window_fill = glsr_pkg::FILL_EMPTY;
  node_t older_node = '0;
  node_t newer_node = '0;

  result_t expected_results[$];
  result_t node_results[$];
  stim_row_t directed_rows[NUM_ROWS];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_hold = 0;
  // When busy_phase is low, neither side idles. When calm is high, the run
  // has reached its last stretch and idling has stopped for good.
  bit busy_phase = 1'b1;
  bit calm = 1'b0;

  grid_line_smoothness_ratio_core #(
    .COORD_WIDTH(COORD_W)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_node_x           (in_node_x),
    .in_node_y           (in_node_y),
    .in_node_valid       (in_node_valid),
    .in_first_in_line    (in_first_in_line),
    .in_last_in_line     (in_last_in_line),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_smoothness_value(out_smoothness_value),
    .out_value_missing   (out_value_missing),
    .out_last_in_run     (out_last_in_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The watchdog ends a run that hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL grid_line_smoothness_ratio_core");
      $finish;
    end
  end

  // Squared length of the edge between two nodes. The differences need one
  // bit more than a coordinate, so the math is done at 64 bits.
  function automatic logic [63:0] squared_edge(node_t p, node_t q);
    longint dx;
    longint dy;
    dx = longint'($signed(q.x)) - longint'($signed(p.x));
    dy = longint'($signed(q.y)) - longint'($signed(p.y));
    return dx * dx + dy * dy;
  endfunction

  // This function returns floor(sqrt(longer / shorter) * 2^16), saturated.
  // It forms the exact quotient longer * 2^32 / shorter and takes its
  // integer root bit by bit. A quotient that needs more than 64 bits would
  // give a root that does not fit in 32 bits.
  function automatic logic [glsr_pkg::RESULT_W-1:0] smoothness_q16(logic [63:0] a,
                                                                   logic [63:0] b);
    logic [63:0]  longer;
    logic [63:0]  shorter;
    logic [127:0] quotient;
    logic [63:0]  root;
    logic [63:0]  trial;
    if (a == 0 || b == 0) begin
      return glsr_pkg::ONE_Q16;
    end
    longer = (a >= b) ? a : b;
    shorter = (a >= b) ? b : a;
    quotient = {32'd0, longer, 32'd0} / {64'd0, shorter};
    if (quotient[127:64] != 0) begin
      return glsr_pkg::SAT_Q16;
    end
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= quotient[63:0]) begin
        root = trial;
      end
    end
    return root[glsr_pkg::RESULT_W-1:0];
  endfunction

  // This task moves the window by one accepted node. It collects the
  // results that the node releases in node_results.
  task automatic advance_window(node_t nd);
    result_t gap_result;
    result_t ratio_result;
    result_t closing;
    gap_result = '{value: glsr_pkg::ZERO_Q16, missing: 1'b1, last_in_run: 1'b0};
    node_results.delete();
    // A new line mark flushes a node that still waits for its successor.
    if (nd.first) begin
      if (window_fill == glsr_pkg::FILL_TWO) begin
        node_results.push_back(gap_result);
      end
      window_fill = glsr_pkg::FILL_EMPTY;
    end
    if (window_fill == glsr_pkg::FILL_EMPTY) begin
      // This node opens a line, whether or not it is marked. It is a line
      // end, so its result is missing and leaves at once.
      node_results.push_back(gap_result);
      if (!nd.last) begin
        newer_node = nd;
        window_fill = glsr_pkg::FILL_ONE;
      end
    end else begin
      if (window_fill == glsr_pkg::FILL_TWO) begin
        if (older_node.node_valid && newer_node.node_valid && nd.node_valid) begin
          ratio_result.value = smoothness_q16(squared_edge(older_node, newer_node),
                                              squared_edge(newer_node, nd));
          ratio_result.missing = 1'b0;
          ratio_result.last_in_run = 1'b0;
          node_results.push_back(ratio_result);
        end else begin
          node_results.push_back(gap_result);
        end
      end
      if (nd.last) begin
        node_results.push_back(gap_result);
        window_fill = glsr_pkg::FILL_EMPTY;
      end else begin
        older_node = newer_node;
        newer_node = nd;
        window_fill = glsr_pkg::FILL_TWO;
      end
    end
    if (node_results.size() != 0) begin
      closing = node_results.pop_back();
      closing.last_in_run = 1'b1;
      node_results.push_back(closing);
    end
  endtask

  // This task offers one node and waits for the block to accept it. Then it
  // queues the expected results: the typed ones when the row gives them, and
  // the model's otherwise. The caller is at a rising edge.
  task automatic send_node(node_t nd, int typed_count, result_t typed_a, result_t typed_b);
    in_valid <= 1'b1;
    in_node_x <= nd.x;
    in_node_y <= nd.y;
    in_node_valid <= nd.node_valid;
    in_first_in_line <= nd.first;
    in_last_in_line <= nd.last;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    // The block has taken the request at this edge.
    advance_window(nd);
    if (typed_count < 0) begin
      foreach (node_results[i]) begin
        expected_results.push_back(node_results[i]);
      end
    end else begin
      if (typed_count >= 1) begin
        typed_a.last_in_run = (typed_count == 1);
        expected_results.push_back(typed_a);
      end
      if (typed_count == 2) begin
        typed_b.last_in_run = 1'b1;
        expected_results.push_back(typed_b);
      end
    end
    if ($urandom_range(0, 39) == 0) begin
      busy_phase = !busy_phase;
    end
    // Valid stays high into the next request unless a gap is taken here.
    if (!calm && busy_phase && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  function automatic stim_row_t row_of(coord_t x, coord_t y, logic nv, logic first,
                                       logic last, int count,
                                       logic [glsr_pkg::RESULT_W-1:0] val_a,
                                       logic miss_a,
                                       logic [glsr_pkg::RESULT_W-1:0] val_b,
                                       logic miss_b);
    stim_row_t r;
    r.nd = '{x: x, y: y, node_valid: nv, first: first, last: last};
    r.typed_count = count;
    r.typed_a = '{value: val_a, missing: miss_a, last_in_run: 1'b0};
    r.typed_b = '{value: val_b, missing: miss_b, last_in_run: 1'b0};
    return r;
  endfunction

  // This function gives one coordinate along a line. The step is usually of
  // random scale. Sometimes it is zero, and sometimes the coordinate jumps
  // to an extreme or to any value at all.
  function automatic coord_t wander(coord_t prev);
    coord_t step;
    case ($urandom_range(0, 9))
      0: begin
        return coord_t'($urandom);
      end
      1: begin
        return prev;
      end
      2: begin
        return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      end
      default: begin
        step = coord_t'($urandom) >>> $urandom_range(0, COORD_W - 1);
        return prev + step;
      end
    endcase
  endfunction

  // The receiver stalls in bursts, with open runs
  // between them.
  always @(posedge clk) begin
    if (!rst_n || calm || !busy_phase) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_hold <= $urandom_range(0, 20);
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_hold <= $urandom_range(0, 8);
    end
  end

  // Every result that the block hands over is checked against the oldest
  // expected result.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: value %h, missing %b, last_in_run %b",
               out_smoothness_value, out_value_missing, out_last_in_run);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_smoothness_value !== want.value) begin
          $error("smoothness_value: expected %h, got %h", want.value, out_smoothness_value);
          mismatch_count++;
        end
        if (out_value_missing !== want.missing) begin
          $error("value_missing: expected %b, got %b", want.missing, out_value_missing);
          mismatch_count++;
        end
        if (out_last_in_run !== want.last_in_run) begin
          $error("last_in_run: expected %b, got %b", want.last_in_run, out_last_in_run);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    node_t  nd;
    coord_t px;
    coord_t py;
    int     line_len;
    int     sent;

    // Arguments are x, y, valid, first, last, then the typed result count
    // and up to two typed results as value and missing.
    // A short line: a missing start, a ratio of exactly two, then a
    // zero-length last edge and the missing line end.
    directed_rows[0]  = row_of(0, 0, 1, 1, 0, 1,
                               glsr_pkg::ZERO_Q16, 1, glsr_pkg::ZERO_Q16, 1);
    directed_rows[1]  = row_of(1, 0, 1, 0, 0, 0,
                               glsr_pkg::ZERO_Q16, 1, glsr_pkg::ZERO_Q16, 1);
    directed_rows[2]  = row_of(3, 0, 1, 0, 0, 1,
                               32'h0002_0000, 0, glsr_pkg::ZERO_Q16, 1);
    directed_rows[3]  = row_of(3, 0, 1, 0, 1, 2,
                               glsr_pkg::ONE_Q16, 0, glsr_pkg::ZERO_Q16, 1);
    // A unit edge followed by the longest possible edge saturates.
    directed_rows[4]  = row_of(COORD_MIN, COORD_MIN, 1, 1, 0, 1,
                               glsr_pkg::ZERO_Q16, 1, glsr_pkg::ZERO_Q16, 1);
    directed_rows[5]  = row_of(COORD_MIN + 1, COORD_MIN, 1, 0, 0, 0,
                               glsr_pkg::ZERO_Q16, 1, glsr_pkg::ZERO_Q16, 1);
    directed_rows[6]  = row_of(COORD_MAX, COORD_MAX, 1, 0, 0, 1,
                               glsr_pkg::SAT_Q16, 0, glsr_pkg::ZERO_Q16, 1);
    directed_rows[7]  = row_of(COORD_MAX, COORD_MAX, 1, 0, 1, 2,
                               glsr_pkg::ONE_Q16, 0, glsr_pkg::ZERO_Q16, 1);
    // A line of a single node.
    directed_rows[8]  = row_of(42, -42, 1, 1, 1, 1,
                               glsr_pkg::ZERO_Q16, 1, glsr_pkg::ZERO_Q16, 1);
    // A node with no line open starts a line of its own accord.
    directed_rows[9]  = row_of(5, 5, 1, 0, 0, 1,
                               glsr_pkg::ZERO_Q16, 1, glsr_pkg::ZERO_Q16, 1);
    directed_rows[10] = row_of(6, 5, 1, 0, 0, 0,
                               glsr_pkg::ZERO_Q16, 1, glsr_pkg::ZERO_Q16, 1);
    // A restart flushes the waiting node as missing, then opens a new line.
    directed_rows[11] = row_of(100, -100, 1, 1, 0, 2,
                               glsr_pkg::ZERO_Q16, 1, glsr_pkg::ZERO_Q16, 1);
    // An invalid node spoils every window it sits in.
    directed_rows[12] = row_of(200, -100, 0, 0, 0, 0,
                               glsr_pkg::ZERO_Q16, 1, glsr_pkg::ZERO_Q16, 1);
    directed_rows[13] = row_of(300, -100, 1, 0, 0, 1,
                               glsr_pkg::ZERO_Q16, 1, glsr_pkg::ZERO_Q16, 1);
    directed_rows[14] = row_of(-300, 7, 1, 0, 0, 1,
                               glsr_pkg::ZERO_Q16, 1, glsr_pkg::ZERO_Q16, 1);
    directed_rows[15] = row_of(-301, 7, 1, 0, 0, -1,
                               glsr_pkg::ZERO_Q16, 1, glsr_pkg::ZERO_Q16, 1);
    directed_rows[16] = row_of(COORD_MIN, COORD_MAX, 1, 0, 0, -1,
                               glsr_pkg::ZERO_Q16, 1, glsr_pkg::ZERO_Q16, 1);
    directed_rows[17] = row_of(COORD_MAX, COORD_MIN, 0, 0, 0, 1,
                               glsr_pkg::ZERO_Q16, 1, glsr_pkg::ZERO_Q16, 1);
    directed_rows[18] = row_of(COORD_MAX, COORD_MAX, 1, 0, 1, 2,
                               glsr_pkg::ZERO_Q16, 1, glsr_pkg::ZERO_Q16, 1);
    // Equal edges give exactly 1.0.
    directed_rows[19] = row_of(0, 0, 1, 1, 0, 1,
                               glsr_pkg::ZERO_Q16, 1, glsr_pkg::ZERO_Q16, 1);
    directed_rows[20] = row_of(1000, 0, 1, 0, 0, 0,
                               glsr_pkg::ZERO_Q16, 1, glsr_pkg::ZERO_Q16, 1);
    directed_rows[21] = row_of(2000, 0, 1, 0, 0, 1,
                               glsr_pkg::ONE_Q16, 0, glsr_pkg::ZERO_Q16, 1);
    // Both marks on one node while a node waits give two missing results.
    directed_rows[22] = row_of(2000, -1000, 1, 1, 1, 2,
                               glsr_pkg::ZERO_Q16, 1, glsr_pkg::ZERO_Q16, 1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NUM_ROWS; r++) begin
      send_node(directed_rows[r].nd, directed_rows[r].typed_count,
                directed_rows[r].typed_a, directed_rows[r].typed_b);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = (RANDOM_ITEMS - sent) <= CALM_ITEMS;
      if ($urandom_range(0, 9) == 0) begin
        // Noise: any coordinates and any marks.
        nd.x = coord_t'($urandom);
        nd.y = coord_t'($urandom);
        nd.node_valid = $urandom_range(0, 1);
        nd.first = $urandom_range(0, 1);
        nd.last = $urandom_range(0, 1);
        send_node(nd, -1, '0, '0);
        sent++;
      end else begin
        // A well-formed line. Now and then a mark is left off, or an extra
        // start appears in the middle of the line.
        line_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
        px = coord_t'($urandom);
        py = coord_t'($urandom);
        for (int k = 0; k < line_len; k++) begin
          px = wander(px);
          py = wander(py);
          nd.x = px;
          nd.y = py;
          nd.node_valid = ($urandom_range(0, 11) != 0);
          nd.first = (k == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 39) == 0);
          nd.last = (k == line_len - 1) ? ($urandom_range(0, 9) != 0) : 1'b0;
          send_node(nd, -1, '0, '0);
          sent++;
        end
      end
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    // Give any stray result the time to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS grid_line_smoothness_ratio_core");
    end else begin
      $display("FAIL grid_line_smoothness_ratio_core");
    end
    $finish;
  end

endmodule
